[rtl/chpp_pkg.sv]
package chpp_pkg;

    // Percentile registers are Q1.16, one is 65536
    localparam int PCT_W     = 17;
    localparam int FRAC_BITS = 16;
    localparam logic [PCT_W-1:0] Q_ONE = 17'd65536;
    localparam logic [PCT_W-1:0] Q_ROUND_UP = 17'd65535;

    localparam int MINPTS_W = 9;
    localparam logic [MINPTS_W-1:0] MINPTS_RESET = 9'd1;

    localparam logic [PCT_W-1:0] GROUND_PCT_RESET = 17'd6554;
    localparam logic [PCT_W-1:0] LOWER_PCT_RESET  = 17'd3277;
    localparam logic [PCT_W-1:0] UPPER_PCT_RESET  = 17'd62259;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GROUND_PCT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_PCT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_PCT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS = 2'd3;

    // Control broadcast to every cell of the sorting chain
    typedef struct packed {
        logic ins;    // insert the broadcast height in order
        logic shift;  // move every entry one cell toward cell 0
    } cell_ctrl_t;

endpackage

[rtl/chpp_cell.sv]
module chpp_cell #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                          clk,
    input  chpp_pkg::cell_ctrl_t          ctrl,
    input  logic signed [HEIGHT_BITS-1:0] height,
    input  logic                          occupied,
    input  logic                          is_tail,
    input  logic signed [HEIGHT_BITS-1:0] left_value,
    input  logic                          left_greater,
    input  logic signed [HEIGHT_BITS-1:0] right_value,
    output logic signed [HEIGHT_BITS-1:0] value,
    output logic                          greater
);

    logic signed [HEIGHT_BITS-1:0] value_reg;
    logic signed [HEIGHT_BITS-1:0] value_next;

    // strictly greater keeps equal heights in arrival order
    assign greater = occupied && (value_reg > height);
    assign value   = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift)
        begin
            value_next = right_value;
        end
        else if (ctrl.ins)
        begin
            if (left_greater)
            begin
                value_next = left_value;
            end
            else if (greater || is_tail)
            begin
                value_next = height;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

[rtl/chpp_index.sv]
module chpp_index #(
    parameter int CNT_W = 9,
    parameter int IDX_W = 8
) (
    input  logic [chpp_pkg::PCT_W-1:0] pct,
    input  logic [CNT_W-1:0]           last,
    input  logic                       round_up,
    output logic [IDX_W-1:0]           idx
);

    localparam int PROD_W = chpp_pkg::PCT_W + CNT_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [chpp_pkg::PCT_W-1:0] pct_c;
    logic [PROD_W-1:0]          prod;
    logic [SUM_W-1:0]           sum;
    logic [SUM_W-1:0]           quot;
    logic [SUM_W-1:0]           last_ext;

    always_comb
    begin
        pct_c    = (pct > chpp_pkg::Q_ONE) ? chpp_pkg::Q_ONE : pct;
        prod     = PROD_W'(pct_c) * PROD_W'(last);
        sum      = SUM_W'(prod)
                 + (round_up ? SUM_W'(chpp_pkg::Q_ROUND_UP) : SUM_W'(0));
        quot     = sum >> chpp_pkg::FRAC_BITS;
        last_ext = SUM_W'(last);
        if (quot > last_ext)
        begin
            quot = last_ext;
        end
        idx = quot[IDX_W-1:0];
    end

endmodule

[rtl/cell_height_percentile_projector_unit.sv]
// Channel   Signals                                        Direction  Handshake
// ------    ---------------------------------------------  ---------  -------------------
// input     height_mm, height_ok, cell_end                 in         start & !busy
// result    ground_mm, low_mm, high_mm, span_mm,           out        done, one cycle
//           valid_count, observed, overflowed
// config    cfg_index, cfg_data                            in         cfg_valid & cfg_ready
//
// An item without cell_end leaves busy low: if height_ok and the chain is not full, its
// height is inserted in order into the sorting chain at the edge that accepts it.
// An item with cell_end holds busy through ST_INDEX, which registers the three index
// multiplies, ST_SCAN, which shifts the kept heights (its own included) out past cell 0,
// and ST_EMIT, which forms the result. Unobserved cells skip the shift-out.
// done is high in the cycle after ST_EMIT.
// Reset clears the FSM, the fill count and the drop flag; the chain is not cleared.
// The receiver cannot stall: done is high for one cycle; results hold until the next one.
module cell_height_percentile_projector_unit #(
    parameter int MAX_POINTS  = 256,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [HEIGHT_BITS-1:0]         height_mm,
    input  logic                                  height_ok,
    input  logic                                  cell_end,

    output logic                                  done,
    output logic signed [HEIGHT_BITS-1:0]         ground_mm,
    output logic signed [HEIGHT_BITS-1:0]         low_mm,
    output logic signed [HEIGHT_BITS-1:0]         high_mm,
    output logic        [HEIGHT_BITS-1:0]         span_mm,
    output logic        [$clog2(MAX_POINTS+1)-1:0] valid_count,
    output logic                                  observed,
    output logic                                  overflowed,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [chpp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [chpp_pkg::PCT_W-1:0]            cfg_data
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CMP_W = (CNT_W > chpp_pkg::MINPTS_W) ? CNT_W : chpp_pkg::MINPTS_W;
    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_POINTS);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_INDEX,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // ---------------- configuration registers ----------------
    logic [chpp_pkg::PCT_W-1:0]    ground_pct_reg;
    logic [chpp_pkg::PCT_W-1:0]    lower_pct_reg;
    logic [chpp_pkg::PCT_W-1:0]    upper_pct_reg;
    logic [chpp_pkg::MINPTS_W-1:0] min_points_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ground_pct_reg <= chpp_pkg::GROUND_PCT_RESET;
            lower_pct_reg  <= chpp_pkg::LOWER_PCT_RESET;
            upper_pct_reg  <= chpp_pkg::UPPER_PCT_RESET;
            min_points_reg <= chpp_pkg::MINPTS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                chpp_pkg::REG_GROUND_PCT: ground_pct_reg <= cfg_data;
                chpp_pkg::REG_LOWER_PCT:  lower_pct_reg  <= cfg_data;
                chpp_pkg::REG_UPPER_PCT:  upper_pct_reg  <= cfg_data;
                chpp_pkg::REG_MIN_POINTS: min_points_reg <= cfg_data[chpp_pkg::MINPTS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- control state ----------------
    state_t                        state_reg;
    logic [CNT_W-1:0]              count_reg;
    logic                          drop_reg;
    logic [IDX_W-1:0]              scan_reg;
    logic [IDX_W-1:0]              last_reg;
    logic [IDX_W-1:0]              ig_reg;
    logic [IDX_W-1:0]              il_reg;
    logic [IDX_W-1:0]              iu_reg;
    logic                          obs_reg;
    logic signed [HEIGHT_BITS-1:0] g_reg;
    logic signed [HEIGHT_BITS-1:0] lo_reg;
    logic signed [HEIGHT_BITS-1:0] hi_reg;

    logic signed [HEIGHT_BITS-1:0] ground_reg;
    logic signed [HEIGHT_BITS-1:0] low_reg;
    logic signed [HEIGHT_BITS-1:0] high_reg;
    logic        [HEIGHT_BITS-1:0] span_reg;
    logic        [CNT_W-1:0]       vcount_reg;
    logic                          observed_reg;
    logic                          overflow_reg;
    logic                          done_reg;

    logic accept;
    logic insert;
    assign accept = start && !busy;
    assign insert = accept && height_ok && (count_reg < CAPACITY);
    assign busy   = (state_reg != ST_LOAD);

    // ---------------- sorting chain ----------------
    chpp_pkg::cell_ctrl_t          cell_ctrl;
    logic signed [HEIGHT_BITS-1:0] chain_value   [MAX_POINTS];
    logic                          chain_greater [MAX_POINTS];

    assign cell_ctrl.ins   = insert;
    assign cell_ctrl.shift = (state_reg == ST_SCAN);

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        logic signed [HEIGHT_BITS-1:0] left_v;
        logic                          left_g;
        logic signed [HEIGHT_BITS-1:0] right_v;

        if (i == 0)
        begin : g_head
            assign left_v = '0;
            assign left_g = 1'b0;
        end
        else
        begin : g_body
            assign left_v = chain_value[i-1];
            assign left_g = chain_greater[i-1];
        end

        if (i == MAX_POINTS - 1)
        begin : g_end
            assign right_v = '0;
        end
        else
        begin : g_mid
            assign right_v = chain_value[i+1];
        end

        chpp_cell #(
            .HEIGHT_BITS (HEIGHT_BITS)
        ) u_cell (
            .clk          (clk),
            .ctrl         (cell_ctrl),
            .height       (height_mm),
            .occupied     (CNT_W'(i) < count_reg),
            .is_tail      (CNT_W'(i) == count_reg),
            .left_value   (left_v),
            .left_greater (left_g),
            .right_value  (right_v),
            .value        (chain_value[i]),
            .greater      (chain_greater[i])
        );
    end

    // ---------------- percentile indexes ----------------
    logic [CNT_W-1:0]          last_w;
    logic [IDX_W-1:0]          ig_w;
    logic [IDX_W-1:0]          il_w;
    logic [IDX_W-1:0]          iu_w;
    logic [chpp_pkg::MINPTS_W-1:0] need_w;
    logic                      obs_w;

    assign last_w = count_reg - CNT_W'(1);
    // a minimum of zero behaves as one
    assign need_w = (min_points_reg == '0) ? chpp_pkg::MINPTS_RESET : min_points_reg;
    assign obs_w  = CMP_W'(count_reg) >= CMP_W'(need_w);

    chpp_index #(.CNT_W(CNT_W), .IDX_W(IDX_W)) u_idx_ground (
        .pct (ground_pct_reg), .last (last_w), .round_up (1'b0), .idx (ig_w)
    );
    chpp_index #(.CNT_W(CNT_W), .IDX_W(IDX_W)) u_idx_lower (
        .pct (lower_pct_reg), .last (last_w), .round_up (1'b0), .idx (il_w)
    );
    chpp_index #(.CNT_W(CNT_W), .IDX_W(IDX_W)) u_idx_upper (
        .pct (upper_pct_reg), .last (last_w), .round_up (1'b1), .idx (iu_w)
    );

    // span saturates to zero when high is not above low
    logic signed [HEIGHT_BITS:0] diff_w;
    logic        [HEIGHT_BITS-1:0] span_w;
    assign diff_w = {hi_reg[HEIGHT_BITS-1], hi_reg} - {lo_reg[HEIGHT_BITS-1], lo_reg};
    assign span_w = (hi_reg > lo_reg) ? diff_w[HEIGHT_BITS-1:0] : '0;

    // ---------------- FSM and registered outputs ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            done_reg  <= 1'b0;
            scan_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (height_ok)
                        begin
                            if (count_reg < CAPACITY)
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                drop_reg <= 1'b1;
                            end
                        end
                        if (cell_end)
                        begin
                            state_reg <= ST_INDEX;
                        end
                    end
                end
                ST_INDEX:
                begin
                    ig_reg   <= ig_w;
                    il_reg   <= il_w;
                    iu_reg   <= iu_w;
                    last_reg <= last_w[IDX_W-1:0];
                    obs_reg  <= obs_w;
                    scan_reg <= '0;
                    g_reg    <= '0;
                    lo_reg   <= '0;
                    hi_reg   <= '0;
                    state_reg <= obs_w ? ST_SCAN : ST_EMIT;
                end
                ST_SCAN:
                begin
                    // cell 0 holds sorted entry scan_reg this cycle
                    if (scan_reg == ig_reg)
                    begin
                        g_reg <= chain_value[0];
                    end
                    if (scan_reg == il_reg)
                    begin
                        lo_reg <= chain_value[0];
                    end
                    if (scan_reg == iu_reg)
                    begin
                        hi_reg <= chain_value[0];
                    end
                    scan_reg <= scan_reg + IDX_W'(1);
                    if (scan_reg == last_reg)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    ground_reg   <= g_reg;
                    low_reg      <= lo_reg;
                    high_reg     <= hi_reg;
                    span_reg     <= span_w;
                    vcount_reg   <= count_reg;
                    observed_reg <= obs_reg;
                    overflow_reg <= drop_reg;
                    done_reg     <= 1'b1;
                    count_reg    <= '0;
                    drop_reg     <= 1'b0;
                    state_reg    <= ST_LOAD;
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign ground_mm   = ground_reg;
    assign low_mm      = low_reg;
    assign high_mm     = high_reg;
    assign span_mm     = span_reg;
    assign valid_count = vcount_reg;
    assign observed    = observed_reg;
    assign overflowed  = overflow_reg;

endmodule

[sim/tb_cell_height_percentile_projector_unit.sv]
`timescale 1ns / 1ps

module tb_cell_height_percentile_projector_unit;

    localparam int H_BITS         = 16;
    localparam int CAPACITY       = 256;
    localparam int COUNT_W        = $clog2(CAPACITY + 1);
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 205;   // rough item budget per config phase
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 300;

    // One point height as queued for the driver
    typedef struct {
        logic signed [H_BITS-1:0] height;
        logic                     ok;
        logic                     is_end;
        int unsigned              wait_cycles;
    } point_t;

    // One predicted cell summary
    typedef struct {
        logic signed [H_BITS-1:0] ground_h;
        logic signed [H_BITS-1:0] low_h;
        logic signed [H_BITS-1:0] high_h;
        logic        [H_BITS-1:0] span_h;
        logic        [COUNT_W-1:0] kept;
        logic                     seen;
        logic                     spilled;
    } cell_summary_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                     start     = 1'b0;
    logic                     busy;
    logic signed [H_BITS-1:0] height_mm = '0;
    logic                     height_ok = 1'b0;
    logic                     cell_end  = 1'b0;

    logic                     done;
    logic signed [H_BITS-1:0] ground_mm;
    logic signed [H_BITS-1:0] low_mm;
    logic signed [H_BITS-1:0] high_mm;
    logic        [H_BITS-1:0] span_mm;
    logic        [COUNT_W-1:0] valid_count;
    logic                     observed;
    logic                     overflowed;

    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [chpp_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [chpp_pkg::PCT_W-1:0]        cfg_data  = '0;

    // Handshake flags, set at the rising edge and read by the falling-edge drivers
    logic in_taken  = 1'b0;
    logic cfg_taken = 1'b0;

    // Pending items for the driver
    point_t point_queue[$];
    point_t held_point;
    logic   item_held = 1'b0;

    // Predictor state: config mirror plus the sorted heights of the open cell
    logic [chpp_pkg::PCT_W-1:0]    ground_q = chpp_pkg::GROUND_PCT_RESET;
    logic [chpp_pkg::PCT_W-1:0]    lower_q  = chpp_pkg::LOWER_PCT_RESET;
    logic [chpp_pkg::PCT_W-1:0]    upper_q  = chpp_pkg::UPPER_PCT_RESET;
    logic [chpp_pkg::MINPTS_W-1:0] min_q    = chpp_pkg::MINPTS_RESET;
    logic signed [H_BITS-1:0] cell_heights[$];
    logic                     cell_spilled = 1'b0;

    cell_summary_t cells_due[$];

    int fail_count   = 0;
    int quiet_cycles = 0;

    cell_height_percentile_projector_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .height_mm   (height_mm),
        .height_ok   (height_ok),
        .cell_end    (cell_end),
        .done        (done),
        .ground_mm   (ground_mm),
        .low_mm      (low_mm),
        .high_mm     (high_mm),
        .span_mm     (span_mm),
        .valid_count (valid_count),
        .observed    (observed),
        .overflowed  (overflowed),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Rank into the sorted cell for a Q1.16 percentile; values above one saturate,
    // rank is clamped to the last entry.
    function automatic int unsigned rank_at(input logic [chpp_pkg::PCT_W-1:0] pct,
                                            input int unsigned top, input bit round_up);
        longint unsigned p;
        longint unsigned prod;
        p = (pct > chpp_pkg::Q_ONE) ? longint'(chpp_pkg::Q_ONE) : longint'(pct);
        prod = p * top + (round_up ? longint'(chpp_pkg::Q_ROUND_UP) : 0);
        prod = prod >> chpp_pkg::FRAC_BITS;
        return (prod > top) ? top : 32'(prod);
    endfunction

    // Insert one accepted height in order; on cell end, form the summary and clear.
    task automatic sort_in_point(input logic signed [H_BITS-1:0] h, input logic ok,
                                 input logic is_end);
        int            pos;
        int unsigned   top;
        int unsigned   need;
        cell_summary_t s;
        if (ok)
        begin
            if (cell_heights.size() < CAPACITY)
            begin
                // equal heights keep arrival order: new one goes after them
                pos = cell_heights.size();
                while (pos > 0 && cell_heights[pos-1] > h)
                    pos--;
                cell_heights.insert(pos, h);
            end
            else
                cell_spilled = 1'b1;
        end
        if (is_end)
        begin
            need = (min_q == 0) ? 1 : min_q;   // a zero minimum still needs one point
            s = '{default: '0};
            s.kept    = COUNT_W'(cell_heights.size());
            s.seen    = (cell_heights.size() >= need);
            s.spilled = cell_spilled;
            if (s.seen)
            begin
                top = cell_heights.size() - 1;
                s.ground_h = cell_heights[rank_at(ground_q, top, 1'b0)];
                s.low_h    = cell_heights[rank_at(lower_q, top, 1'b0)];
                s.high_h   = cell_heights[rank_at(upper_q, top, 1'b1)];
                // upper below lower gives no span rather than a negative one
                if (s.high_h > s.low_h)
                    s.span_h = s.high_h - s.low_h;
            end
            cells_due.insert(cells_due.size(), s);
            cell_heights.delete();
            cell_spilled = 1'b0;
        end
    endtask

    task automatic check_field(input string label, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, exp_v, act_v);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: results, accepted items, register writes, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_ports
        cell_summary_t want;
        logic          hit;
        hit = 1'b0;
        in_taken  <= rst_n && start && !busy;
        cfg_taken <= rst_n && cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (done)
            begin
                hit = 1'b1;
                if (cells_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with nothing expected, actual ground %0d low %0d",
                             $time, ground_mm, low_mm);
                    $display("%0t: expected no result, actual high %0d count %0d",
                             $time, high_mm, valid_count);
                end
                else
                begin
                    want = cells_due[0];
                    cells_due.delete(0);
                    check_field("ground_mm",   want.ground_h, ground_mm);
                    check_field("low_mm",      want.low_h,    low_mm);
                    check_field("high_mm",     want.high_h,   high_mm);
                    check_field("span_mm",     want.span_h,   span_mm);
                    check_field("valid_count", want.kept,     valid_count);
                    check_field("observed",    want.seen,     observed);
                    check_field("overflowed",  want.spilled,  overflowed);
                end
            end
            if (start && !busy)
            begin
                hit = 1'b1;
                sort_in_point(height_mm, height_ok, cell_end);
            end
            if (cfg_valid && cfg_ready)
            begin
                hit = 1'b1;
                case (cfg_index)
                    chpp_pkg::REG_GROUND_PCT: ground_q = cfg_data;
                    chpp_pkg::REG_LOWER_PCT:  lower_q  = cfg_data;
                    chpp_pkg::REG_UPPER_PCT:  upper_q  = cfg_data;
                    chpp_pkg::REG_MIN_POINTS: min_q    = cfg_data[chpp_pkg::MINPTS_W-1:0];
                    default: ;
                endcase
            end
            if (hit)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[cell_height_percentile_projector_unit] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: one item at a time from point_queue, with its drawn wait
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_points
        if (!rst_n)
            start <= 1'b0;
        else if (!start || in_taken)
        begin
            if (!item_held && point_queue.size() > 0)
            begin
                held_point = point_queue[0];
                point_queue.delete(0);
                item_held  = 1'b1;
            end
            if (item_held && held_point.wait_cycles == 0)
            begin
                height_mm <= held_point.height;
                height_ok <= held_point.ok;
                cell_end  <= held_point.is_end;
                start     <= 1'b1;
                item_held  = 1'b0;
            end
            else
            begin
                if (item_held)
                    held_point.wait_cycles--;
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic signed [H_BITS-1:0] draw_height();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1: return 16'($urandom_range(0, 8)) - 16'sd4;          // heavy duplicates
            2: return 16'($urandom_range(0, 4000)) - 16'sd2000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_point(input logic signed [H_BITS-1:0] h, input logic ok,
                              input logic is_end, input bit no_wait);
        point_t p;
        p.height      = h;
        p.ok          = ok;
        p.is_end      = is_end;
        p.wait_cycles = no_wait ? 0 : $urandom_range(0, 3);
        point_queue.insert(point_queue.size(), p);
    endtask

    // A well-formed cell of n_pts items, last one closing it
    task automatic queue_cell(input int n_pts, input int ok_pct);
        bit burst;
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n_pts; i++)
            push_point(draw_height(), ($urandom_range(0, 99) < ok_pct),
                       (i == n_pts - 1), burst);
    endtask

    // n_valid good heights, a dropped one inside, closed by a dropped item
    task automatic queue_big_cell(input int n_valid);
        for (int i = 0; i < n_valid; i++)
        begin
            if (i == n_valid / 2)
                push_point(draw_height(), 1'b0, 1'b0, 1'b0);
            push_point(draw_height(), 1'b1, 1'b0, 1'b0);
        end
        push_point(draw_height(), 1'b0, 1'b1, 1'b0);
    endtask

    task automatic wait_idle();
        while (!(point_queue.size() == 0 && !item_held && !start && cells_due.size() == 0))
            @(negedge clk);
        repeat (4) @(negedge clk);   // let the last cell's tail clear
    endtask

    // Leaves cfg_valid high on return so back-to-back writes need no drop
    task automatic write_reg(input logic [chpp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [chpp_pkg::PCT_W-1:0] val);
        int unsigned gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_taken);
    endtask

    initial
    begin : run_phases
        logic [chpp_pkg::PCT_W-1:0] g_pct;
        logic [chpp_pkg::PCT_W-1:0] lo_pct;
        logic [chpp_pkg::PCT_W-1:0] up_pct;
        logic [chpp_pkg::PCT_W-1:0] min_raw;
        int               budget;
        int               r;
        int               n;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 0)
            begin
                // reset settings: single extremes, empty cell, dropped closer,
                // mixed order with a dropped item inside, duplicates
                push_point(16'sh7FFF, 1'b1, 1'b1, 1'b0);
                push_point(16'sh8000, 1'b1, 1'b1, 1'b0);
                push_point(16'sh0000, 1'b0, 1'b1, 1'b0);
                push_point(16'sh7FFF, 1'b1, 1'b0, 1'b0);
                push_point(16'sh8000, 1'b1, 1'b0, 1'b0);
                push_point(16'sh1234, 1'b0, 1'b1, 1'b0);
                push_point(16'sd5,    1'b1, 1'b0, 1'b0);
                push_point(-16'sd3,   1'b1, 1'b0, 1'b0);
                push_point(16'sd100,  1'b1, 1'b0, 1'b0);
                push_point(16'shFFFF, 1'b0, 1'b0, 1'b0);
                push_point(16'sh7FFF, 1'b1, 1'b0, 1'b0);
                push_point(16'sh8000, 1'b1, 1'b0, 1'b0);
                push_point(16'sd7,    1'b1, 1'b1, 1'b0);
                push_point(16'sd1,    1'b1, 1'b0, 1'b1);
                push_point(16'sd1,    1'b1, 1'b0, 1'b1);
                push_point(16'sd1,    1'b1, 1'b1, 1'b1);
                budget = PHASE_ITEMS - 16;
            end
            else
            begin
                wait_idle();
                case (ph)
                    1: begin g_pct = '0; lo_pct = '0; up_pct = chpp_pkg::Q_ONE;
                             min_raw = 17'd1; end
                    // upper below lower, zero minimum
                    2: begin g_pct = chpp_pkg::Q_ONE; lo_pct = chpp_pkg::Q_ONE; up_pct = '0;
                             min_raw = '0; end
                    // percentiles above one, minimum equal to capacity
                    3: begin g_pct = 17'h1FFFF; lo_pct = 17'd70000; up_pct = 17'd98304;
                             min_raw = 17'd256; end
                    // minimum above capacity: nothing observed
                    4: begin g_pct  = 17'($urandom_range(0, 131071));
                             lo_pct = 17'($urandom_range(0, 131071));
                             up_pct = 17'($urandom_range(0, 131071));
                             min_raw = 17'd300; end
                    // bits above the minimum's width are ignored (leaves 3)
                    5: begin g_pct = 17'd32768; lo_pct = 17'd16384; up_pct = 17'd49152;
                             min_raw = 17'h1F003; end
                    6: begin g_pct  = 17'($urandom_range(0, 131071));
                             lo_pct = 17'($urandom_range(0, 131071));
                             up_pct = 17'($urandom_range(0, 131071));
                             min_raw = {8'($urandom), 9'($urandom_range(1, 6))}; end
                    default: begin g_pct  = 17'($urandom_range(0, 65536));
                                   lo_pct = 17'($urandom_range(0, 65536));
                                   up_pct = 17'($urandom_range(0, 65536));
                                   min_raw = 17'd2; end
                endcase
                write_reg(chpp_pkg::REG_GROUND_PCT, g_pct);
                write_reg(chpp_pkg::REG_LOWER_PCT,  lo_pct);
                write_reg(chpp_pkg::REG_UPPER_PCT,  up_pct);
                write_reg(chpp_pkg::REG_MIN_POINTS, min_raw);
                cfg_valid <= 1'b0;
                budget = PHASE_ITEMS;
            end

            // store overflow, and an exactly full store under a minimum of capacity
            if (ph == 1)
            begin
                queue_big_cell(CAPACITY + 3);
                budget -= CAPACITY + 5;
            end
            if (ph == 3)
            begin
                queue_big_cell(CAPACITY);
                budget -= CAPACITY + 2;
            end

            // mostly short cells, some medium, a few long; some all-dropped
            while (budget > 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                begin
                    n = $urandom_range(1, 3);
                    queue_cell(n, 0);
                end
                else if (r < 75)
                begin
                    n = $urandom_range(1, 8);
                    queue_cell(n, 90);
                end
                else if (r < 95)
                begin
                    n = $urandom_range(9, 40);
                    queue_cell(n, 85);
                end
                else
                begin
                    n = $urandom_range(41, 120);
                    queue_cell(n, 95);
                end
                budget -= n;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("[cell_height_percentile_projector_unit] OK");
        else
            $display("[cell_height_percentile_projector_unit] ERROR");
        $finish;
    end

endmodule
